[sv/fpa_pkg.sv]
// fpa_pkg: beat types, opcodes and pipeline control types for the fixed point alu
// no dependencies
`default_nettype none
package fpa_pkg;

   localparam logic [3:0] OP_ADD = 4'd0;
   localparam logic [3:0] OP_SUB = 4'd1;
   localparam logic [3:0] OP_MUL = 4'd2;
   localparam logic [3:0] OP_DIV = 4'd3;
   localparam logic [3:0] OP_MOD = 4'd4;
   localparam logic [3:0] OP_NEG = 4'd5;
   localparam logic [3:0] OP_ABS = 4'd6;
   localparam logic [3:0] OP_INV = 4'd7;
   localparam logic [3:0] OP_INC = 4'd8;
   localparam logic [3:0] OP_DEC = 4'd9;
   localparam logic [3:0] OP_RATIO = 4'd10;

   localparam logic [1:0] KIND_SIMPLE = 2'd0;
   localparam logic [1:0] KIND_QUO = 2'd1;
   localparam logic [1:0] KIND_REM = 2'd2;

   localparam int DIV_STEPS = 64;

   typedef struct packed {
      logic [3:0]         opcode;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result;
      logic               zero_divisor;
      logic               is_equal;
      logic               is_greater;
      logic               is_less;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] simple;
      logic        negate;
      logic        zero_divisor;
      logic        is_equal;
      logic        is_greater;
      logic        is_less;
   } ctrl_type;

endpackage
`default_nettype wire

[sv/fixed_point_alu.sv]
// fixed_point_alu: pipelined scaled-integer alu, top level
// depends on fpa_pkg, fpa_front, fpa_div_step
//
//   beat      valid      stall      payload
//   request   req_valid  req_stall  req_data (fpa_pkg::req_type)
//   response  rsp_valid  rsp_stall  rsp_data (fpa_pkg::rsp_type)
//
// one beat per cycle while no held response stalls it; stages: multiplier, operand set-up,
// 64 restoring division steps and the output register
// every operation flows through the full pipeline, in order
// the whole pipeline advances unless a response beat is held by rsp_stall
// synchronous reset empties the pipeline
`default_nettype none
module fixed_point_alu #(
   parameter int SCALE = 10000
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire fpa_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output fpa_pkg::rsp_type      rsp_data
);
   import fpa_pkg::*;

   logic        en;
   logic        v_pipe [0:DIV_STEPS];
   ctrl_type    c_pipe [0:DIV_STEPS];
   logic [31:0] r_pipe [0:DIV_STEPS];
   logic [63:0] n_pipe [0:DIV_STEPS];
   logic [31:0] d_pipe [0:DIV_STEPS];

   logic        out_valid_ff;
   rsp_type     out_ff, out_in;
   ctrl_type    last;
   logic [31:0] quo, rem;

   assign en = ~(out_valid_ff & rsp_stall);
   assign req_stall = ~en;
   assign r_pipe[0] = 32'd0;

   fpa_front #(.SCALE(SCALE)) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .in_data  (req_data),
      .out_valid(v_pipe[0]),
      .out_ctrl (c_pipe[0]),
      .out_nq   (n_pipe[0]),
      .out_d    (d_pipe[0])
   );

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
      fpa_div_step u_step (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (v_pipe[i]),
         .in_ctrl  (c_pipe[i]),
         .in_rem   (r_pipe[i]),
         .in_nq    (n_pipe[i]),
         .in_d     (d_pipe[i]),
         .out_valid(v_pipe[i+1]),
         .out_ctrl (c_pipe[i+1]),
         .out_rem  (r_pipe[i+1]),
         .out_nq   (n_pipe[i+1]),
         .out_d    (d_pipe[i+1])
      );
   end

   always_comb begin
      last = c_pipe[DIV_STEPS];
      quo = n_pipe[DIV_STEPS][31:0];
      rem = r_pipe[DIV_STEPS];
      out_in.zero_divisor = last.zero_divisor;
      out_in.is_equal = last.is_equal;
      out_in.is_greater = last.is_greater;
      out_in.is_less = last.is_less;
      case (last.kind)
         KIND_QUO: out_in.result = last.negate ? -quo : quo;
         KIND_REM: out_in.result = last.negate ? -rem : rem;
         default:  out_in.result = last.simple;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= v_pipe[DIV_STEPS];
      end
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;

   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_divisor |-> rsp_data.result == 32'd0)
      else $error("zero divisor beat with nonzero result");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a held response");

   a_cmp_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_data.is_equal, rsp_data.is_greater, rsp_data.is_less}))
      else $error("comparison flags not exclusive");

endmodule
`default_nettype wire

[sv/fpa_front.sv]
// fpa_front: multiplier stage and divider operand set-up stage
// depends on fpa_pkg
`default_nettype none
module fpa_front #(
   parameter int SCALE = 10000
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire fpa_pkg::req_type in_data,
   output logic                  out_valid,
   output fpa_pkg::ctrl_type     out_ctrl,
   output logic [63:0]           out_nq,
   output logic [31:0]           out_d
);
   import fpa_pkg::*;

   localparam logic [63:0] SCALE_SQ = 64'(SCALE) * 64'(SCALE);

   logic               v1_ff;
   req_type            r1_ff;
   logic signed [63:0] prod_ff;
   logic signed [31:0] mul_b;

   logic               v2_ff, v2_in;
   ctrl_type           c2_ff, c2_in;
   logic [63:0]        nq2_ff, nq2_in;
   logic [31:0]        d2_ff, d2_in;

   logic signed [63:0] num;
   logic signed [31:0] den;

   assign mul_b = (in_data.opcode == OP_MUL) ? in_data.operand_b : 32'(SCALE);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
      if (en) begin
         r1_ff   <= in_data;
         prod_ff <= 64'(in_data.operand_a) * 64'(mul_b);
      end
   end

   always_comb begin
      logic signed [31:0] a, b;
      a = r1_ff.operand_a;
      b = r1_ff.operand_b;
      v2_in = v1_ff;
      c2_in.kind = KIND_SIMPLE;
      c2_in.simple = 32'd0;
      c2_in.negate = 1'b0;
      c2_in.zero_divisor = 1'b0;
      c2_in.is_equal = (a == b);
      c2_in.is_greater = (a > b);
      c2_in.is_less = (a < b);
      num = prod_ff;
      den = b;
      case (r1_ff.opcode)
         OP_ADD: c2_in.simple = 32'(a + b);
         OP_SUB: c2_in.simple = 32'(a - b);
         OP_NEG: c2_in.simple = 32'(-a);
         OP_ABS: c2_in.simple = a[31] ? 32'(-a) : 32'(a);
         OP_INC: c2_in.simple = 32'(a + 32'sd1);
         OP_DEC: c2_in.simple = 32'(a - 32'sd1);
         OP_MUL: begin
            c2_in.kind = KIND_QUO;
            den = 32'(SCALE);
         end
         OP_DIV, OP_RATIO: begin
            c2_in.kind = (b == 0) ? KIND_SIMPLE : KIND_QUO;
            c2_in.zero_divisor = (b == 0);
         end
         OP_MOD: begin
            c2_in.kind = (b == 0) ? KIND_SIMPLE : KIND_REM;
            c2_in.zero_divisor = (b == 0);
            num = 64'(a);
         end
         OP_INV: begin
            c2_in.kind = (a == 0) ? KIND_SIMPLE : KIND_QUO;
            c2_in.zero_divisor = (a == 0);
            num = SCALE_SQ;
            den = a;
         end
         default: c2_in.simple = 32'd0;
      endcase
      if (c2_in.kind == KIND_REM) begin
         c2_in.negate = num[63];
      end else begin
         c2_in.negate = num[63] ^ den[31];
      end
      nq2_in = num[63] ? 64'(-num) : 64'(num);
      d2_in = den[31] ? 32'(-den) : 32'(den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v2_in;
      end
      if (en) begin
         c2_ff  <= c2_in;
         nq2_ff <= nq2_in;
         d2_ff  <= d2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_ctrl = c2_ff;
   assign out_nq = nq2_ff;
   assign out_d = d2_ff;

endmodule
`default_nettype wire

[sv/fpa_div_step.sv]
// fpa_div_step: one restoring division step, one quotient bit per stage
// depends on fpa_pkg
`default_nettype none
module fpa_div_step (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire fpa_pkg::ctrl_type in_ctrl,
   input  wire logic [31:0]       in_rem,
   input  wire logic [63:0]       in_nq,
   input  wire logic [31:0]       in_d,
   output logic                   out_valid,
   output fpa_pkg::ctrl_type      out_ctrl,
   output logic [31:0]            out_rem,
   output logic [63:0]            out_nq,
   output logic [31:0]            out_d
);
   import fpa_pkg::*;

   logic        valid_ff;
   ctrl_type    ctrl_ff;
   logic [31:0] rem_ff, rem_in, d_ff;
   logic [63:0] nq_ff, nq_in;
   logic [32:0] part;
   logic [33:0] diff;
   logic        ge;

   assign part = {in_rem, in_nq[63]};
   assign diff = {1'b0, part} - {2'b00, in_d};
   assign ge = ~diff[33];
   assign rem_in = ge ? diff[31:0] : part[31:0];
   assign nq_in = {in_nq[62:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         ctrl_ff <= in_ctrl;
         rem_ff  <= rem_in;
         nq_ff   <= nq_in;
         d_ff    <= in_d;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctrl = ctrl_ff;
   assign out_rem = rem_ff;
   assign out_nq = nq_ff;
   assign out_d = d_ff;

endmodule
`default_nettype wire
